// ----- hdl/cmdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared types, constants and helpers of the command line character parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

	localparam int NUM_TEMPLATES  = 4;
	localparam int TEMPLATE_LEN   = 8;
	localparam int PARAM_BUF_SIZE = 64;
	localparam int LINE_END_CHAR  = 10;

	localparam int TMPL_SLOTS  = 4;
	localparam int TMPL_IDX_W  = 2;
	localparam int TMPL_BYTES  = 8;
	localparam int POS_W       = 4;
	localparam int CNT_W       = $clog2(PARAM_BUF_SIZE);
	localparam int PIDX_W      = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] NUL_CHAR      = 8'd0;
	localparam logic [7:0] LINE_END      = 8'(LINE_END_CHAR);
	localparam logic [7:0] SPACE_CHAR    = 8'd32;
	localparam logic [7:0] FIRST_WS_CHAR = 8'd9;
	localparam logic [7:0] LAST_WS_CHAR  = 8'd13;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_0   = 3'd4;

	typedef logic [TMPL_BYTES-1:0][7:0] tmpl_text_t;

	typedef enum logic [1:0] {
		CLS_TEXT,
		CLS_SPACE,
		CLS_END
	} char_class_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_CMD,
		PH_PARAM,
		PH_DUMP
	} phase_t;

	typedef enum logic [1:0] {
		ST_CONT,
		ST_DONE,
		ST_PARSE_ERR,
		ST_PARAM_ERR
	} status_t;

	typedef struct packed {
		logic [7:0]  ch;
		char_class_t cls;
	} item_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		if (c == NUL_CHAR || c == LINE_END) begin
			r = CLS_END;
		end else if (c == SPACE_CHAR || (c >= FIRST_WS_CHAR && c <= LAST_WS_CHAR)) begin
			r = CLS_SPACE;
		end else begin
			r = CLS_TEXT;
		end
		return r;
	endfunction

	function automatic logic [7:0] tmpl_byte(input tmpl_text_t text,
			input logic [POS_W-1:0] pos);
		logic [7:0] r;
		if (pos >= POS_W'(TEMPLATE_LEN)) begin
			r = NUL_CHAR;
		end else begin
			r = text[pos[2:0]];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cmdp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cmdp_front
// Input stage: takes characters, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module cmdp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     in_char,
	output logic                push_valid,
	input  wire logic           push_ready,
	output cmdp_pkg::item_t     push_item
);
	import cmdp_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.ch  <= in_char;
			item_s1.cls <= classify(in_char);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cmdp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cmdp_queue
// Short queue of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module cmdp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire cmdp_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output cmdp_pkg::item_t      pop_item
);
	import cmdp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ----- hdl/cmdp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cmdp_back
// Parse engine: template match, parameter emit, end-of-line status, and the
// result register toward the output channel. Holds the configuration.
// ----------------------------------------------------------------------------
module cmdp_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [cmdp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cmdp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 head_valid,
	output logic                                      head_ready,
	input  wire cmdp_pkg::item_t                      head_item,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [1:0]                                status,
	output logic [7:0]                                command_id,
	output logic                                      param_valid,
	output logic [7:0]                                param_char,
	output logic [cmdp_pkg::PIDX_W-1:0]               param_index
);
	import cmdp_pkg::*;

	// configuration
	tmpl_text_t         text_q [TMPL_SLOTS];
	logic [7:0]         id_q   [TMPL_SLOTS];

	// parse state
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q  [TMPL_SLOTS];
	logic [POS_W-1:0]   pos_d  [TMPL_SLOTS];
	logic [TMPL_SLOTS-1:0] failed_q, failed_d;
	logic [7:0]         pend_res_q, pend_res_d;
	status_t            pend_err_q, pend_err_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;

	// result register
	logic               out_valid_q;
	status_t            status_q, status_d;
	logic [7:0]         cmd_id_q, cmd_id_d;
	logic               pvalid_q, pvalid_d;
	logic [7:0]         pchar_q, pchar_d;
	logic [PIDX_W-1:0]  pidx_q, pidx_d;

	logic               take;
	logic [7:0]         cur_byte [TMPL_SLOTS];
	logic [POS_W-1:0]   feed_pos [TMPL_SLOTS];
	logic [TMPL_SLOTS-1:0] feed_fail;
	logic               match_found;
	logic [7:0]         match_id;
	logic [CNT_W:0]     cnt_inc;
	logic               room;
	logic               clear;

	assign head_ready = !out_valid_q || out_ready;
	assign take       = head_valid && head_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign command_id  = cmd_id_q;
	assign param_valid = pvalid_q;
	assign param_char  = pchar_q;
	assign param_index = pidx_q;

	assign cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign room    = cnt_inc < (CNT_W + 1)'(PARAM_BUF_SIZE);

	// template compare, lowest-numbered live template wins
	always_comb begin
		match_found = 1'b0;
		match_id    = '0;
		for (int t = 0; t < TMPL_SLOTS; t++) begin
			cur_byte[t] = tmpl_byte(text_q[t], pos_q[t]);
			feed_pos[t] = pos_q[t];
			feed_fail[t] = failed_q[t];
			if (t < NUM_TEMPLATES && !failed_q[t]) begin
				if (cur_byte[t] == head_item.ch) begin
					feed_pos[t] = pos_q[t] + POS_W'(1);
				end else begin
					feed_fail[t] = 1'b1;
				end
			end
		end
		for (int t = TMPL_SLOTS - 1; t >= 0; t--) begin
			if (t < NUM_TEMPLATES && !failed_q[t] && cur_byte[t] == NUL_CHAR &&
					id_q[t] != '0) begin
				match_found = 1'b1;
				match_id    = id_q[t];
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_START: begin
				if (head_item.cls == CLS_TEXT) begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (head_item.cls == CLS_SPACE) begin
					phase_d = match_found ? PH_PARAM : PH_DUMP;
				end else if (head_item.cls == CLS_END) begin
					phase_d = PH_START;
				end
			end
			PH_PARAM: begin
				if (head_item.cls == CLS_END) begin
					phase_d = PH_START;
				end else if (!room) begin
					phase_d = PH_DUMP;
				end
			end
			PH_DUMP: begin
				if (head_item.cls == CLS_END) begin
					phase_d = PH_START;
				end
			end
			default: phase_d = PH_START;
		endcase
	end

	// datapath and result
	always_comb begin
		pos_d      = pos_q;
		failed_d   = failed_q;
		pend_res_d = pend_res_q;
		pend_err_d = pend_err_q;
		cnt_d      = cnt_q;
		status_d   = ST_CONT;
		cmd_id_d   = '0;
		pvalid_d   = 1'b0;
		pchar_d    = '0;
		pidx_d     = '0;
		clear      = 1'b0;
		case (phase_q)
			PH_START: begin
				if (head_item.cls == CLS_TEXT) begin
					pos_d    = feed_pos;
					failed_d = feed_fail;
				end
			end
			PH_CMD: begin
				if (head_item.cls == CLS_TEXT) begin
					pos_d    = feed_pos;
					failed_d = feed_fail;
				end else if (head_item.cls == CLS_SPACE) begin
					if (match_found) begin
						pend_res_d = match_id;
					end else begin
						pend_err_d = ST_PARSE_ERR;
					end
				end else begin
					status_d = match_found ? ST_DONE : ST_PARSE_ERR;
					cmd_id_d = match_found ? match_id : '0;
					clear    = 1'b1;
				end
			end
			PH_PARAM: begin
				if (head_item.cls == CLS_END) begin
					status_d = ST_DONE;
					cmd_id_d = pend_res_q;
					clear    = 1'b1;
				end else if (room) begin
					pvalid_d = 1'b1;
					pchar_d  = head_item.ch;
					pidx_d   = PIDX_W'(cnt_q);
					cnt_d    = cnt_inc[CNT_W-1:0];
				end else begin
					pend_err_d = ST_PARAM_ERR;
				end
			end
			PH_DUMP: begin
				if (head_item.cls == CLS_END) begin
					status_d = pend_err_q;
					clear    = 1'b1;
				end
			end
			default: clear = 1'b1;
		endcase
		if (clear) begin
			for (int t = 0; t < TMPL_SLOTS; t++) begin
				pos_d[t] = '0;
			end
			failed_d   = '0;
			pend_res_d = '0;
			pend_err_d = ST_CONT;
			cnt_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TMPL_SLOTS; t++) begin
				text_q[t] <= '0;
				id_q[t]   <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_ID_0) begin
				text_q[cfg_index[TMPL_IDX_W-1:0]] <= cfg_data;
			end else begin
				id_q[cfg_index[TMPL_IDX_W-1:0]] <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			for (int t = 0; t < TMPL_SLOTS; t++) begin
				pos_q[t] <= '0;
			end
			failed_q    <= '0;
			pend_res_q  <= '0;
			pend_err_q  <= ST_CONT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			failed_q    <= failed_d;
			pend_res_q  <= pend_res_d;
			pend_err_q  <= pend_err_d;
			cnt_q       <= cnt_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			cmd_id_q <= cmd_id_d;
			pvalid_q <= pvalid_d;
			pchar_q  <= pchar_d;
			pidx_q   <= pidx_d;
		end
	end

`ifndef SYNTH
	a_param_only_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pvalid_q |-> status_q == ST_CONT)
		else $error("parameter character with final status");
	a_id_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DONE |-> cmd_id_q == '0)
		else $error("command id outside command done");
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> cnt_q == '0 && pend_res_q == '0 && failed_q == '0)
		else $error("stale parse state at line start");
`endif

endmodule
`default_nettype wire

// ----- hdl/command_line_char_parser_core.sv -----
// Path: a character passes the input register, the queue write and the parse step
// into the result register; a stall can hold it at each of them.
// Throughput: one character per cycle while out_ready is held high; the parse step in the back
// end sets it, and the queue lets front and back stall independently.
// Reset: parser returns to line start, templates and ids clear to zero, queue empty.
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_char_parser_core
// Command line character parser: front classifier, queue, parse back end.
// ----------------------------------------------------------------------------
module command_line_char_parser_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cmdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cmdp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      in_char,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           status,
	output logic [7:0]                           command_id,
	output logic                                 param_valid,
	output logic [7:0]                           param_char,
	output logic [cmdp_pkg::PIDX_W-1:0]          param_index
);
	import cmdp_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  head_valid;
	logic  head_ready;
	item_t head_item;

	cmdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	cmdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_item   (head_item)
	);

	cmdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.head_valid  (head_valid),
		.head_ready  (head_ready),
		.head_item   (head_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.command_id  (command_id),
		.param_valid (param_valid),
		.param_char  (param_char),
		.param_index (param_index)
	);

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command line character parser. Characters are
// pushed through the valid/ready input with random gaps, every reply is
// pulled with random stalls and compared against a cycle-free parser model.
// Template words and ids are reloaded between runs of lines, covering named
// words, all-ones and empty words, disabled ids, priority and random words.
// ----------------------------------------------------------------------------
module testbench;
	import cmdp_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [7:0]          cmd_id;
		logic                pvalid;
		logic [7:0]          pchar;
		logic [PIDX_W-1:0]   pindex;
	} reply_t;

	class line_parser_model;
		logic [63:0] word_text [NUM_TEMPLATES];
		logic [7:0]  word_id [NUM_TEMPLATES];
		phase_t      phase;
		logic [3:0]  match_pos [NUM_TEMPLATES];
		bit          match_dead [NUM_TEMPLATES];
		logic [7:0]  held_id;
		status_t     held_status;
		int unsigned stored;
		reply_t      expected_replies [$];
		int          mismatches;
		int          n_done, n_parse_err, n_param_err, n_params;

		function new();
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				word_text[t] = '0;
				word_id[t] = '0;
			end
			restart_line();
			mismatches = 0;
			n_done = 0;
			n_parse_err = 0;
			n_param_err = 0;
			n_params = 0;
		endfunction

		function void restart_line();
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				match_pos[t] = '0;
				match_dead[t] = 0;
			end
			phase = PH_START;
			held_id = '0;
			held_status = ST_CONT;
			stored = 0;
		endfunction

		function void write_reg(int idx, logic [63:0] v);
			if (idx < NUM_TEMPLATES) begin
				word_text[idx] = v;
			end else begin
				word_id[idx - NUM_TEMPLATES] = v[7:0];
			end
		endfunction

		function char_class_t kind_of(logic [7:0] c);
			if (c == NUL_CHAR || c == LINE_END) begin
				return CLS_END;
			end
			if (c == SPACE_CHAR || (c >= FIRST_WS_CHAR && c <= LAST_WS_CHAR)) begin
				return CLS_SPACE;
			end
			return CLS_TEXT;
		endfunction

		function logic [7:0] word_char(int t, int pos);
			if (pos >= TEMPLATE_LEN) begin
				return NUL_CHAR;
			end
			return word_text[t][8*pos +: 8];
		endfunction

		function void advance_words(logic [7:0] c);
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				if (!match_dead[t]) begin
					if (word_char(t, match_pos[t]) == c) begin
						match_pos[t] = match_pos[t] + 4'd1;
					end else begin
						match_dead[t] = 1;
					end
				end
			end
		endfunction

		function logic [7:0] winning_id();
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				if (!match_dead[t] && word_char(t, match_pos[t]) == NUL_CHAR &&
						word_id[t] != 8'd0) begin
					return word_id[t];
				end
			end
			return 8'd0;
		endfunction

		function void take_char(logic [7:0] c);
			reply_t      r;
			char_class_t k;
			logic [7:0]  hit;
			r = '0;
			r.status = ST_CONT;
			k = kind_of(c);
			case (phase)
				PH_START: begin
					if (k == CLS_TEXT) begin
						phase = PH_CMD;
						advance_words(c);
					end
				end
				PH_CMD: begin
					if (k == CLS_TEXT) begin
						advance_words(c);
					end else begin
						hit = winning_id();
						if (k == CLS_SPACE) begin
							if (hit != 8'd0) begin
								held_id = hit;
								phase = PH_PARAM;
							end else begin
								held_status = ST_PARSE_ERR;
								phase = PH_DUMP;
							end
						end else begin
							if (hit != 8'd0) begin
								r.status = ST_DONE;
								r.cmd_id = hit;
							end else begin
								r.status = ST_PARSE_ERR;
							end
							restart_line();
						end
					end
				end
				PH_PARAM: begin
					if (k == CLS_END) begin
						r.status = ST_DONE;
						r.cmd_id = held_id;
						restart_line();
					end else if (stored + 1 < PARAM_BUF_SIZE) begin
						r.pvalid = 1'b1;
						r.pchar = c;
						r.pindex = PIDX_W'(stored);
						stored++;
						n_params++;
					end else begin
						held_status = ST_PARAM_ERR;
						phase = PH_DUMP;
					end
				end
				default: begin
					if (k == CLS_END) begin
						r.status = held_status;
						restart_line();
					end
				end
			endcase
			case (r.status)
				ST_DONE: n_done++;
				ST_PARSE_ERR: n_parse_err++;
				ST_PARAM_ERR: n_param_err++;
				default: ;
			endcase
			expected_replies.push_back(r);
		endfunction

		function void match_reply(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with nothing expected: status=%0d id=%0d pv=%0d char=%0d idx=%0d",
					$time, got.status, got.cmd_id, got.pvalid, got.pchar, got.pindex);
				mismatches++;
				return;
			end
			want = expected_replies.pop_front();
			if (got !== want) begin
				$display("%0t: reply mismatch: expected status=%0d id=%0d pv=%0d char=%0d idx=%0d",
					$time, want.status, want.cmd_id, want.pvalid, want.pchar, want.pindex);
				$display("%0t:                 actual   status=%0d id=%0d pv=%0d char=%0d idx=%0d",
					$time, got.status, got.cmd_id, got.pvalid, got.pchar, got.pindex);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            in_char;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [7:0]            command_id;
	logic                  param_valid;
	logic [7:0]            param_char;
	logic [PIDX_W-1:0]     param_index;

	line_parser_model parser_model;
	logic [63:0]      new_text [NUM_TEMPLATES];
	logic [7:0]       new_id [NUM_TEMPLATES];
	int               chars_sent;
	int               phase_chars;
	int               settings_used;
	bit               long_hold_req;
	bit               send_burst;
	bit               recv_burst;

	command_line_char_parser_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] pack_word(string s);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < s.len() && i < TEMPLATE_LEN; i++) begin
			r[8*i +: 8] = s[i];
		end
		return r;
	endfunction

	function automatic logic [7:0] ws_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? SPACE_CHAR : FIRST_WS_CHAR + 8'(r);
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] r;
		r = 8'($urandom_range(0, 255));
		while (parser_model.kind_of(r) != CLS_TEXT) begin
			r = 8'($urandom_range(0, 255));
		end
		return r;
	endfunction

	function automatic logic [7:0] end_char();
		return $urandom_range(0, 1) ? NUL_CHAR : LINE_END;
	endfunction

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		// transfer done at this edge
		parser_model.take_char(c);
		chars_sent++;
		phase_chars++;
		if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
	endtask

	task automatic apply_settings();
		in_valid <= 1'b0;
		while (parser_model.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 2 * NUM_TEMPLATES; i++) begin
			cfg_we <= 1'b1;
			if (i < NUM_TEMPLATES) begin
				cfg_index <= CFG_TEXT_0 + CFG_IDX_W'(i);
				cfg_data <= new_text[i];
				parser_model.write_reg(i, new_text[i]);
			end else begin
				cfg_index <= CFG_ID_0 + CFG_IDX_W'(i - NUM_TEMPLATES);
				cfg_data <= CFG_DATA_W'(new_id[i - NUM_TEMPLATES]);
				parser_model.write_reg(i, 64'(new_id[i - NUM_TEMPLATES]));
			end
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_line();
		logic [7:0] line [$];
		logic [7:0] w [$];
		logic [7:0] b;
		int         t, n, mode;
		if ($urandom_range(0, 9) == 0) begin
			// noise
			n = $urandom_range(1, 12);
			repeat (n) line.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) line.push_back(ws_char());
			t = $urandom_range(0, NUM_TEMPLATES - 1);
			for (int p = 0; p < TEMPLATE_LEN; p++) begin
				b = parser_model.word_text[t][8*p +: 8];
				if (b == NUL_CHAR) break;
				w.push_back(b);
			end
			if (w.size() == 0 || $urandom_range(0, 9) == 0) begin
				w.delete();
				n = $urandom_range(1, 9);
				repeat (n) w.push_back(text_char());
			end else begin
				mode = $urandom_range(0, 7);
				if (mode == 0 && w.size() > 1) begin
					void'(w.pop_back());
				end else if (mode == 1) begin
					w.push_back(text_char());
				end else if (mode == 2) begin
					w[$urandom_range(0, w.size() - 1)] = text_char();
				end
			end
			foreach (w[i]) line.push_back(w[i]);
			if ($urandom_range(0, 2) != 0) begin
				line.push_back(ws_char());
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					while (parser_model.kind_of(b) == CLS_END) b = 8'($urandom_range(0, 255));
					line.push_back(b);
				end
			end
			line.push_back(end_char());
		end
		foreach (line[i]) send_char(line[i]);
	endtask

	task automatic random_lines(input int target);
		phase_chars = 0;
		while (phase_chars < target) send_line();
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		reply_t got;
		int     stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				stall = 200;
				long_hold_req = 0;
			end else begin
				stall = recv_burst ? 0 : $urandom_range(0, 19);
			end
			if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			got = '{status_t'(status), command_id, param_valid, param_char, param_index};
			@(posedge clk);
			parser_model.match_reply(got);
		end
	end

	initial begin
		logic [7:0] directed [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_char = '0;
		long_hold_req = 0;
		send_burst = 0;
		recv_burst = 0;
		chars_sent = 0;
		phase_chars = 0;
		settings_used = 0;
		parser_model = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// named words, one a prefix of another
		new_text[0] = pack_word("go");
		new_text[1] = pack_word("goto");
		new_text[2] = pack_word("set");
		new_text[3] = pack_word("reset");
		new_id[0] = 8'd1;
		new_id[1] = 8'd2;
		new_id[2] = 8'd3;
		new_id[3] = 8'd4;
		apply_settings();
		directed = '{LINE_END, NUL_CHAR, 8'd9, 8'd13, SPACE_CHAR, LINE_END,
			"g", "o", LINE_END,
			"g", "o", "t", "o", SPACE_CHAR, "x", 8'hFF, 8'h80, NUL_CHAR,
			"z", "z", LINE_END,
			"s", "e", SPACE_CHAR, "q", LINE_END};
		foreach (directed[i]) send_char(directed[i]);
		long_hold_req = 1;
		random_lines(240);

		// extremes: all-ones word, empty word, disabled id, priority on duplicates
		new_text[0] = '1;
		new_text[1] = '0;
		new_text[2] = pack_word("abcdefgh");
		new_text[3] = pack_word("abcdefgh");
		new_id[0] = 8'hFF;
		new_id[1] = 8'hFF;
		new_id[2] = 8'h00;
		new_id[3] = 8'h80;
		apply_settings();
		random_lines(240);

		repeat (4) begin
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				new_text[t] = '0;
				for (int i = 0; i < $urandom_range(1, TEMPLATE_LEN); i++) begin
					new_text[t][8*i +: 8] = text_char();
				end
				new_id[t] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			end
			if ($urandom_range(0, 1)) new_text[3] = new_text[$urandom_range(0, 2)];
			apply_settings();
			random_lines(240);
		end

		in_valid <= 1'b0;
		while (parser_model.pending() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run: %0d characters under %0d template settings, %0d commands done",
			chars_sent, settings_used, parser_model.n_done);
		$display("run: %0d parse errors, %0d parameter errors, %0d parameter characters",
			parser_model.n_parse_err, parser_model.n_param_err, parser_model.n_params);
		if (parser_model.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/cmdp_pkg.sv
hdl/cmdp_front.sv
hdl/cmdp_queue.sv
hdl/cmdp_back.sv
hdl/command_line_char_parser_core.sv
test/testbench.sv
